// ===== hw/rtl/ladder_lowpass_4pole_zdf_unit_assert.svh =====
// Assertion macros shared by the checker of the ladder low-pass unit.
// Depends on nothing; include by bare file name.
`ifndef LADDER_LOWPASS_4POLE_ZDF_UNIT_ASSERT_SVH
`define LADDER_LOWPASS_4POLE_ZDF_UNIT_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define LDF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define LDF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ldf_pkg.sv =====
// Types and constants of the ladder low-pass unit: microcode word, control struct,
// register indexes. Depends on nothing.
`timescale 1ns / 1ps

package ldf_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_STAGE_GAIN    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FEEDBACK_GAIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_NORM_GAIN     = 2'd2;

  // Reset cutoff gain in Q0.16; rescaled to the coefficient width at the top level.
  localparam int GAIN_RESET_Q16 = 4030;

  typedef logic [3:0] step_t;
  typedef logic [1:0] idx_t;

  localparam idx_t  IDX_LAST    = 2'd3;
  localparam step_t STEP_HORNER = 4'd1;
  localparam step_t STEP_STAGE  = 4'd12;

  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_LOAD_S,
    ALU_V_ADD_S,
    ALU_X_SUB_V,
    ALU_V_SUB_S,
    ALU_ACC_SUB_NEXT
  } alu_op_t;

  typedef enum logic [1:0] {
    ST_HOLD,
    ST_ROT,
    ST_ROT_WR
  } st_op_t;

  typedef enum logic {
    MOP_ACC,
    MOP_V
  } mop_t;

  typedef enum logic [1:0] {
    CO_G,
    CO_ONE_MINUS_G,
    CO_K,
    CO_NORM
  } coef_sel_t;

  typedef struct packed {
    alu_op_t   alu_op;
    st_op_t    st_op;
    logic      mul_en;
    mop_t      mul_op;
    coef_sel_t coef_sel;
    logic      rnd_en;
    logic      idx_inc;
    logic      jmp_en;
    step_t     jmp_tgt;
    logic      emit;
  } ucode_t;

  localparam ucode_t UCODE_NOP = '{
    alu_op:   ALU_NONE,
    st_op:    ST_HOLD,
    mul_en:   1'b0,
    mul_op:   MOP_ACC,
    coef_sel: CO_G,
    rnd_en:   1'b0,
    idx_inc:  1'b0,
    jmp_en:   1'b0,
    jmp_tgt:  4'd0,
    emit:     1'b0
  };

  typedef struct packed {
    logic load;
    logic fire;
    logic emit;
  } seq_ctl_t;

endpackage

// ===== hw/rtl/ldf_ucode_rom.sv =====
// Microprogram ROM of the ladder low-pass unit: one control word per step.
// Depends on ldf_pkg.
`timescale 1ns / 1ps

module ldf_ucode_rom (
  input  ldf_pkg::step_t  step,
  output ldf_pkg::ucode_t cw
);

  always_comb begin
    cw = ldf_pkg::UCODE_NOP;
    case (step)
      // Horner feedback sum over rotating states, resonance, normalisation
      4'd0: begin
        cw.alu_op  = ldf_pkg::ALU_LOAD_S;
        cw.st_op   = ldf_pkg::ST_ROT;
        cw.idx_inc = 1'b1;
      end
      4'd1: begin
        cw.mul_en   = 1'b1;
        cw.mul_op   = ldf_pkg::MOP_ACC;
        cw.coef_sel = ldf_pkg::CO_G;
      end
      4'd2: cw.rnd_en = 1'b1;
      4'd3: begin
        cw.alu_op  = ldf_pkg::ALU_V_ADD_S;
        cw.st_op   = ldf_pkg::ST_ROT;
        cw.idx_inc = 1'b1;
        cw.jmp_en  = 1'b1;
        cw.jmp_tgt = ldf_pkg::STEP_HORNER;
      end
      4'd4: begin
        cw.mul_en   = 1'b1;
        cw.mul_op   = ldf_pkg::MOP_ACC;
        cw.coef_sel = ldf_pkg::CO_ONE_MINUS_G;
      end
      4'd5: cw.rnd_en = 1'b1;
      4'd6: begin
        cw.mul_en   = 1'b1;
        cw.mul_op   = ldf_pkg::MOP_V;
        cw.coef_sel = ldf_pkg::CO_K;
      end
      4'd7: cw.rnd_en = 1'b1;
      4'd8: cw.alu_op = ldf_pkg::ALU_X_SUB_V;
      4'd9: begin
        cw.mul_en   = 1'b1;
        cw.mul_op   = ldf_pkg::MOP_ACC;
        cw.coef_sel = ldf_pkg::CO_NORM;
      end
      4'd10: cw.rnd_en = 1'b1;
      4'd11: cw.alu_op = ldf_pkg::ALU_V_SUB_S;
      // one-pole stage loop
      4'd12: begin
        cw.mul_en   = 1'b1;
        cw.mul_op   = ldf_pkg::MOP_ACC;
        cw.coef_sel = ldf_pkg::CO_G;
      end
      4'd13: cw.rnd_en = 1'b1;
      4'd14: cw.alu_op = ldf_pkg::ALU_V_ADD_S;
      4'd15: begin
        cw.alu_op  = ldf_pkg::ALU_ACC_SUB_NEXT;
        cw.st_op   = ldf_pkg::ST_ROT_WR;
        cw.idx_inc = 1'b1;
        cw.jmp_en  = 1'b1;
        cw.jmp_tgt = ldf_pkg::STEP_STAGE;
        cw.emit    = 1'b1;
      end
      default: cw = ldf_pkg::UCODE_NOP;
    endcase
  end

endmodule

// ===== hw/rtl/ldf_seq.sv =====
// Sequencer of the ladder low-pass unit: step counter, loop index, jumps, handshakes.
// Depends on ldf_pkg.
`timescale 1ns / 1ps

module ldf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ldf_pkg::ucode_t   cw,
  output ldf_pkg::step_t    step,
  output ldf_pkg::seq_ctl_t ctl
);

  logic           busy_r, busy_nxt;
  logic           out_valid_r, out_valid_nxt;
  ldf_pkg::step_t step_r, step_nxt;
  ldf_pkg::idx_t  idx_r, idx_nxt;
  logic           jump_taken;
  logic           stall;

  assign step      = step_r;
  assign in_ready  = !busy_r;
  assign out_valid = out_valid_r;

  always_comb begin
    jump_taken = cw.jmp_en && (idx_r != ldf_pkg::IDX_LAST);
    // hold the last step while the previous result still waits
    stall      = busy_r && cw.emit && !jump_taken && out_valid_r && !out_ready;
    ctl.load   = in_valid && !busy_r;
    ctl.fire   = busy_r && !stall;
    ctl.emit   = ctl.fire && cw.emit && !jump_taken;
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    idx_nxt  = idx_r;
    if (ctl.load) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      idx_nxt  = '0;
    end else if (ctl.fire) begin
      step_nxt = jump_taken ? cw.jmp_tgt : step_r + 1'b1;
      if (cw.idx_inc) begin
        idx_nxt = idx_r + 1'b1;
      end
      if (ctl.emit) begin
        busy_nxt = 1'b0;
      end
    end
    if (ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      idx_r       <= idx_nxt;
    end
  end

endmodule

// ===== hw/rtl/ldf_dp.sv =====
// Datapath of the ladder low-pass unit: shared multiplier with rounding stage,
// saturating adder, accumulator and the rotating line of four stage states.
// Depends on ldf_pkg.
`timescale 1ns / 1ps

module ldf_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 32,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ldf_pkg::seq_ctl_t              ctl,
  input  ldf_pkg::ucode_t                cw,
  input  logic        [COEF_WIDTH-1:0]   stage_gain,
  input  logic        [COEF_WIDTH-1:0]   feedback_gain,
  input  logic        [COEF_WIDTH:0]     norm_gain,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out
);

  localparam int N  = SAMPLE_WIDTH;
  localparam int SW = STATE_WIDTH;
  localparam int F  = COEF_WIDTH;
  localparam int CW = F + 1;
  localparam int PW = SW + CW;
  localparam int RW = PW + 1;
  localparam int XW = ((N > SW) ? N : SW) + 1;

  localparam logic [RW-1:0] POS_LIM = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic [RW-1:0] NEG_LIM = {{(RW-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
  localparam logic [RW-1:0] HALF_G  = {{(RW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic [RW-1:0] HALF_K  = {{(RW-F+3){1'b0}}, 1'b1, {(F-4){1'b0}}};

  localparam logic signed [XW-1:0] ST_MAX_X  = {{(XW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [XW-1:0] ST_MIN_X  = {{(XW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [XW-1:0] SMP_MAX_X = {{(XW-N+1){1'b0}}, {(N-1){1'b1}}};
  localparam logic signed [XW-1:0] SMP_MIN_X = {{(XW-N+1){1'b1}}, {(N-1){1'b0}}};

  function automatic logic signed [SW-1:0] sat_st(input logic signed [XW-1:0] d);
    logic signed [SW-1:0] r;
    if (d > ST_MAX_X) begin
      r = ST_MAX_X[SW-1:0];
    end else if (d < ST_MIN_X) begin
      r = ST_MIN_X[SW-1:0];
    end else begin
      r = d[SW-1:0];
    end
    return r;
  endfunction

  logic signed [SW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0] v_r;
  logic signed [N-1:0]  x_r;
  logic signed [N-1:0]  sample_out_r;
  logic        [PW-1:0] prod_r;
  logic                 neg_r;
  logic                 shk_r;
  logic signed [SW-1:0] s_r   [4];
  logic signed [SW-1:0] s_nxt [4];

  logic        [CW-1:0] coef;
  logic signed [SW-1:0] mop;
  logic        [SW-1:0] mag;
  logic        [RW-1:0] rsum;
  logic        [RW-1:0] rq;
  logic        [RW-1:0] lim;
  logic        [RW-1:0] rmag;
  logic signed [SW-1:0] v_rnd;
  logic signed [SW-1:0] st_wr;
  logic signed [XW-1:0] out_ext;
  logic signed [N-1:0]  out_sat;

  assign sample_out = sample_out_r;

  // multiplier operand and coefficient
  always_comb begin
    case (cw.coef_sel)
      ldf_pkg::CO_G:           coef = {1'b0, stage_gain};
      ldf_pkg::CO_ONE_MINUS_G: coef = {1'b1, {F{1'b0}}} - {1'b0, stage_gain};
      ldf_pkg::CO_K:           coef = {1'b0, feedback_gain};
      ldf_pkg::CO_NORM:        coef = norm_gain;
      default:                 coef = '0;
    endcase
    mop = (cw.mul_op == ldf_pkg::MOP_V) ? v_r : acc_r;
    mag = mop[SW-1] ? (~$unsigned(mop)) + 1'b1 : $unsigned(mop);
  end

  // round to nearest on the magnitude (ties away from zero), clamp, restore sign
  always_comb begin
    rsum  = {1'b0, prod_r} + (shk_r ? HALF_K : HALF_G);
    rq    = shk_r ? (rsum >> (F - 3)) : (rsum >> F);
    lim   = neg_r ? NEG_LIM : POS_LIM;
    rmag  = (rq > lim) ? lim : rq;
    v_rnd = neg_r ? $signed(~rmag[SW-1:0] + 1'b1) : $signed(rmag[SW-1:0]);
  end

  always_comb begin
    st_wr = sat_st(XW'(acc_r) + XW'(v_r));
    case (cw.alu_op)
      ldf_pkg::ALU_LOAD_S:       acc_nxt = s_r[0];
      ldf_pkg::ALU_V_ADD_S:      acc_nxt = sat_st(XW'(v_r) + XW'(s_r[0]));
      ldf_pkg::ALU_X_SUB_V:      acc_nxt = sat_st(XW'(x_r) - XW'(v_r));
      ldf_pkg::ALU_V_SUB_S:      acc_nxt = sat_st(XW'(v_r) - XW'(s_r[0]));
      ldf_pkg::ALU_ACC_SUB_NEXT: acc_nxt = sat_st(XW'(acc_r) - XW'(s_r[1]));
      default:                   acc_nxt = acc_r;
    endcase
  end

  // rotate the state line so the stage in use always sits at the head
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s_nxt[i] = s_r[i];
    end
    case (cw.st_op)
      ldf_pkg::ST_ROT: begin
        for (int i = 0; i < 3; i++) begin
          s_nxt[i] = s_r[i+1];
        end
        s_nxt[3] = s_r[0];
      end
      ldf_pkg::ST_ROT_WR: begin
        for (int i = 0; i < 3; i++) begin
          s_nxt[i] = s_r[i+1];
        end
        s_nxt[3] = st_wr;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_ext = XW'(acc_r);
    if (out_ext > SMP_MAX_X) begin
      out_sat = SMP_MAX_X[N-1:0];
    end else if (out_ext < SMP_MIN_X) begin
      out_sat = SMP_MIN_X[N-1:0];
    end else begin
      out_sat = out_ext[N-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        s_r[i] <= '0;
      end
    end else if (ctl.fire) begin
      for (int i = 0; i < 4; i++) begin
        s_r[i] <= s_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= sample_in;
    end
    if (ctl.fire) begin
      acc_r <= acc_nxt;
      if (cw.mul_en) begin
        prod_r <= PW'(mag) * PW'(coef);
        neg_r  <= mop[SW-1];
        shk_r  <= (cw.coef_sel == ldf_pkg::CO_K);
      end
      if (cw.rnd_en) begin
        v_r <= v_rnd;
      end
    end
    if (ctl.emit) begin
      sample_out_r <= out_sat;
    end
  end

endmodule

// ===== hw/rtl/ladder_lowpass_4pole_zdf_unit.sv =====
// Four-pole zero-delay-feedback ladder low-pass filter, one sample in, one sample out.
// A microprogram of 16 steps runs on one shared multiplier: the feedback sum in Horner
// form, the resonance feedback and input normalisation, then four trapezoidal one-pole
// stages. A sample runs from acceptance to a valid result through the dependent chain
// of 10 multiplications, each a multiply step followed by a rounding step, and 14 load,
// add and subtract steps; a new sample can be taken in the same cycle as the previous
// result appears. A finished result waits in the output register while the next sample
// is already being worked on; the last step holds if that register is still full.
// Software writes the prewarped gain G (Q0.F), the feedback gain k (Q3.F-3) and the
// normalising gain 1/(1+kG^4) (Q1.F) while the unit is idle; indexes beyond these
// three are ignored. Depends on ldf_pkg, ldf_ucode_rom, ldf_seq, ldf_dp.
`timescale 1ns / 1ps

module ladder_lowpass_4pole_zdf_unit #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int STATE_WIDTH  = 32,
  parameter int COEF_WIDTH   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample_in,
  // filtered sample channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample_out,
  // register write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ldf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [COEF_WIDTH:0]                 cfg_data
);

  // Reset gain is given in Q0.16; rescale it through a 24-bit intermediate.
  localparam logic [COEF_WIDTH-1:0] STAGE_GAIN_RST =
    COEF_WIDTH'((ldf_pkg::GAIN_RESET_Q16 << 8) >> (24 - COEF_WIDTH));
  localparam logic [COEF_WIDTH:0]   NORM_GAIN_RST  = {1'b1, {COEF_WIDTH{1'b0}}};

  logic [COEF_WIDTH-1:0] stage_gain_r, stage_gain_nxt;
  logic [COEF_WIDTH-1:0] feedback_gain_r, feedback_gain_nxt;
  logic [COEF_WIDTH:0]   norm_gain_r, norm_gain_nxt;

  ldf_pkg::step_t    step;
  ldf_pkg::ucode_t   cw;
  ldf_pkg::seq_ctl_t ctl;

  // Registers take every write transaction; software must only write while idle, as the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_comb begin
    stage_gain_nxt    = stage_gain_r;
    feedback_gain_nxt = feedback_gain_r;
    norm_gain_nxt     = norm_gain_r;
    if (cfg_valid) begin
      case (cfg_index)
        ldf_pkg::REG_STAGE_GAIN:    stage_gain_nxt    = cfg_data[COEF_WIDTH-1:0];
        ldf_pkg::REG_FEEDBACK_GAIN: feedback_gain_nxt = cfg_data[COEF_WIDTH-1:0];
        ldf_pkg::REG_NORM_GAIN:     norm_gain_nxt     = cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_gain_r    <= STAGE_GAIN_RST;
      feedback_gain_r <= '0;
      norm_gain_r     <= NORM_GAIN_RST;
    end else begin
      stage_gain_r    <= stage_gain_nxt;
      feedback_gain_r <= feedback_gain_nxt;
      norm_gain_r     <= norm_gain_nxt;
    end
  end

  // Fetch the control word of the current step.
  ldf_ucode_rom u_rom (
    .step (step),
    .cw   (cw)
  );

  // Advance the step counter, take jumps, run both handshakes.
  ldf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cw        (cw),
    .step      (step),
    .ctl       (ctl)
  );

  // Multiply, round, add and hold the four stage states.
  ldf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .cw            (cw),
    .stage_gain    (stage_gain_r),
    .feedback_gain (feedback_gain_r),
    .norm_gain     (norm_gain_r),
    .sample_in     (in_sample_in),
    .sample_out    (out_sample_out)
  );

endmodule

// ===== hw/rtl/ldf_checker.sv =====
// Port-level checker of the ladder low-pass unit, bound to the top level.
// Depends on ladder_lowpass_4pole_zdf_unit_assert.svh.
`timescale 1ns / 1ps
`include "ladder_lowpass_4pole_zdf_unit_assert.svh"

module ldf_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_sample_out
);

  // a waiting result holds its value
  `LDF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_out), "result changed while stalled")

  // one sample at a time: input closes right after a transaction
  `LDF_ASSERT_NEXT(a_in_busy, clk, rst_n, in_valid && in_ready, !in_ready, "input open while busy")

  // no result appears the cycle after a sample is taken
  `LDF_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid, "result too early")

  // a fresh result frees the input
  `LDF_ASSERT_IMPL(a_done_free, clk, rst_n, $rose(out_valid), in_ready, "input not free after result")

endmodule

bind ladder_lowpass_4pole_zdf_unit ldf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ldf_checker (.*);

// ===== tb/ladder_lowpass_4pole_zdf_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the four-pole ladder low-pass unit: a directed table, then
// random register settings and samples, each result checked against a fixed-point model
// or a hand-typed value. Depends on ldf_pkg and ladder_lowpass_4pole_zdf_unit.

module ladder_lowpass_4pole_zdf_unit_test;

  localparam int SW  = 24;  // sample width
  localparam int STW = 32;  // state and intermediate width
  localparam int CW  = 16;  // coefficient width

  localparam longint STATE_MAX  = (64'sd1 <<< (STW - 1)) - 1;
  localparam longint STATE_MIN  = -STATE_MAX - 1;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  localparam logic signed [SW-1:0] SMP_MAX = 24'sh7fffff;
  localparam logic signed [SW-1:0] SMP_MIN = 24'sh800000;

  // The index port is two bits wide; this code is not a register, so writes to it vanish.
  localparam logic [ldf_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam int IDLE_PCT      = 13;
  localparam int TAIL_CYCLES   = 80;      // idle tail after draining, to catch stray results
  localparam int CYCLE_LIMIT   = 400000;  // watchdog limit for the whole run
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 100;

  // One row of the directed table: either a register write or a sample, the latter
  // optionally carrying a hand-typed expected output.
  typedef enum logic { ROW_CFG, ROW_SAMPLE } row_kind_t;

  typedef struct packed {
    row_kind_t                        kind;
    logic [ldf_pkg::CFG_INDEX_W-1:0]  index;
    logic [CW:0]                      data;
    logic signed [SW-1:0]             smp;
    logic                             has_want;
    logic signed [SW-1:0]             want;
  } row_t;

  localparam int DIRECTED_ROWS = 33;

  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    // Out of reset all states are zero: silence stays silent.
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      24'sd0,      1'b1, 24'sd0},
    // Zero cutoff gain: the integrators never move, so full-scale input gives zero.
    '{ROW_CFG,    ldf_pkg::REG_STAGE_GAIN,    17'd0,      24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b1, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MIN,     1'b1, 24'sd0},
    // Zero normalising gain with empty states: the chain input is zero.
    '{ROW_CFG,    ldf_pkg::REG_STAGE_GAIN,    17'd4030,   24'sd0,      1'b0, 24'sd0},
    '{ROW_CFG,    ldf_pkg::REG_NORM_GAIN,     17'd0,      24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b1, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MIN,     1'b1, 24'sd0},
    // Plain low-pass at the reset cutoff.
    '{ROW_CFG,    ldf_pkg::REG_NORM_GAIN,     17'd65536,  24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MIN,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      -24'sd1,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      24'sd1,      1'b0, 24'sd0},
    // Widest cutoff and full resonance, driven with full-scale alternation.
    '{ROW_CFG,    ldf_pkg::REG_STAGE_GAIN,    17'd65535,  24'sd0,      1'b0, 24'sd0},
    '{ROW_CFG,    ldf_pkg::REG_FEEDBACK_GAIN, 17'd32768,  24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MIN,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MIN,     1'b0, 24'sd0},
    // Gains above their stated range: the chain must saturate, not wrap.
    '{ROW_CFG,    ldf_pkg::REG_FEEDBACK_GAIN, 17'd65535,  24'sd0,      1'b0, 24'sd0},
    '{ROW_CFG,    ldf_pkg::REG_NORM_GAIN,     17'd131071, 24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MIN,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      24'sd0,      1'b0, 24'sd0},
    // Top data bit must be dropped for the 16-bit registers; unused index ignored.
    '{ROW_CFG,    ldf_pkg::REG_STAGE_GAIN,    17'h10064,  24'sd0,      1'b0, 24'sd0},
    '{ROW_CFG,    ldf_pkg::REG_FEEDBACK_GAIN, 17'h12000,  24'sd0,      1'b0, 24'sd0},
    '{ROW_CFG,    REG_UNUSED,                 17'h1ffff,  24'sd0,      1'b0, 24'sd0},
    '{ROW_CFG,    ldf_pkg::REG_NORM_GAIN,     17'd52429,  24'sd0,      1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MAX,     1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      24'sh555555, 1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      24'shaaaaaa, 1'b0, 24'sd0},
    '{ROW_SAMPLE, ldf_pkg::REG_STAGE_GAIN,    17'd0,      SMP_MIN,     1'b0, 24'sd0}
  };

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic signed [SW-1:0]              in_sample_in = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [SW-1:0]              out_sample_out;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [ldf_pkg::CFG_INDEX_W-1:0]   cfg_index = '0;
  logic [CW:0]                       cfg_data = '0;

  // Filter model: register copies and the four integrator states.
  logic [CW-1:0]                cutoff_gain;
  logic [CW-1:0]                resonance_gain;
  logic [CW:0]                  input_norm;
  longint                       integ_state [4];

  logic signed [SW-1:0]         filtered_q [$];  // expected outputs, oldest first
  int                           mismatches = 0;
  int                           cycle_count = 0;
  bit                           steady = 1'b0;   // suppress idling on both sides

  ladder_lowpass_4pole_zdf_unit #(
    .SAMPLE_WIDTH(SW),
    .STATE_WIDTH (STW),
    .COEF_WIDTH  (CW)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Scale a by c / 2^sh, round half away from zero on the magnitude, then saturate.
  function automatic longint round_scale(longint a, longint unsigned c, int unsigned sh);
    bit              neg;
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned r;
    longint unsigned cap;
    neg = (a < 0);
    mag = neg ? -a : a;
    hi  = mag >> sh;
    lo  = mag & ((64'd1 << sh) - 64'd1);
    r   = hi * c + ((lo * c + (64'd1 << (sh - 1))) >> sh);
    cap = STATE_MAX + 1;
    if (r > cap) r = cap;
    return clip(neg ? -longint'(r) : longint'(r), STATE_MIN, STATE_MAX);
  endfunction

  // One sample through the ladder: Horner feedback sum, resonance subtraction and
  // normalisation, then four trapezoidal one-pole stages. Advances the model state.
  function automatic logic signed [SW-1:0] filter_sample(logic signed [SW-1:0] x_in);
    longint               x;
    longint               acc;
    longint               fsum;
    longint               ks;
    longint               u;
    longint               s;
    longint               v;
    longint               y;
    longint unsigned      gc;
    longint unsigned      omg;
    logic signed [SW-1:0] res;
    x   = longint'(x_in);
    gc  = 64'(cutoff_gain);
    omg = (64'd1 << CW) - gc;
    acc = integ_state[0];
    for (int i = 1; i < 4; i++)
      acc = clip(round_scale(acc, gc, CW) + integ_state[i], STATE_MIN, STATE_MAX);
    fsum = round_scale(acc, omg, CW);
    ks   = round_scale(fsum, 64'(resonance_gain), CW - 3);
    u    = clip(x - ks, STATE_MIN, STATE_MAX);
    u    = round_scale(u, 64'(input_norm), CW);
    for (int i = 0; i < 4; i++) begin
      s = integ_state[i];
      v = round_scale(clip(u - s, STATE_MIN, STATE_MAX), gc, CW);
      y = clip(v + s, STATE_MIN, STATE_MAX);
      integ_state[i] = clip(y + v, STATE_MIN, STATE_MAX);
      u = y;
    end
    res = SW'(clip(u, SAMPLE_MIN, SAMPLE_MAX));
    return res;
  endfunction

  // Offer one register write and hold it until the transaction completes. Leave
  // cfg_valid high; the caller drops it once the burst of writes is done.
  task automatic write_reg(logic [ldf_pkg::CFG_INDEX_W-1:0] idx, logic [CW:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ldf_pkg::REG_STAGE_GAIN:    cutoff_gain    = data[CW-1:0];
      ldf_pkg::REG_FEEDBACK_GAIN: resonance_gain = data[CW-1:0];
      ldf_pkg::REG_NORM_GAIN:     input_norm     = data;
      default: ;
    endcase
  endtask

  // Offer one sample, after a random idle gap unless running steady. Leave in_valid
  // high so that a following sample goes out back to back.
  task automatic send_sample(logic signed [SW-1:0] smp, logic has_want,
                             logic signed [SW-1:0] want);
    logic signed [SW-1:0] predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = filter_sample(smp);
    filtered_q.push_back(has_want ? want : predicted);
  endtask

  // Hold until every outstanding sample has come back.
  task automatic drain();
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted transaction against the oldest expectation,
  // then pick the ready for the next edge.
  always @(posedge clk) begin : result_check
    logic signed [SW-1:0] want_out;
    if (rst_n && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected sample_out %0d with nothing pending", $time,
                 out_sample_out);
        mismatches++;
      end else begin
        want_out = filtered_q.pop_front();
        if (out_sample_out !== want_out) begin
          $display("%0t: sample_out expected %0d, got %0d", $time, want_out,
                   out_sample_out);
          mismatches++;
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ladder_lowpass_4pole_zdf_unit_test NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CW-1:0]        g_pick;
    logic [CW-1:0]        k_pick;
    logic [CW:0]          n_pick;
    logic signed [SW-1:0] smp;
    real                  g_real;
    real                  k_real;
    real                  n_real;

    cutoff_gain    = CW'(ldf_pkg::GAIN_RESET_Q16);
    resonance_gain = '0;
    input_norm     = 17'd1 << CW;
    for (int i = 0; i < 4; i++) integ_state[i] = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table. Registers only change with nothing in flight.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_CFG) begin
        if (in_valid) in_valid <= 1'b0;
        drain();
        write_reg(DIRECTED[r].index, DIRECTED[r].data);
      end else begin
        if (cfg_valid) cfg_valid <= 1'b0;
        send_sample(DIRECTED[r].smp, DIRECTED[r].has_want, DIRECTED[r].want);
      end
    end

    // Random phases: fresh register settings, then a run of samples. Two phases in
    // the middle run with no idling on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      in_valid <= 1'b0;
      drain();
      steady = (p == 6 || p == 7);

      case ($urandom_range(5))
        0:       g_pick = '0;
        1:       g_pick = '1;
        2:       g_pick = CW'($urandom());
        default: g_pick = CW'($urandom_range(8000, 200));
      endcase
      case ($urandom_range(4))
        0:       k_pick = '0;
        1:       k_pick = 16'd32768;
        2:       k_pick = '1;
        default: k_pick = CW'($urandom_range(32768));
      endcase
      // Half the time the normalising gain that software would compute; otherwise anything.
      case ($urandom_range(5))
        0:       n_pick = '0;
        1:       n_pick = '1;
        2:       n_pick = (CW + 1)'($urandom());
        default: begin
          g_real = g_pick / 65536.0;
          k_real = k_pick / 8192.0;
          n_real = 65536.0 / (1.0 + k_real * g_real * g_real * g_real * g_real);
          n_pick = (CW + 1)'($rtoi(n_real + 0.5));
        end
      endcase

      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, (CW + 1)'($urandom()));
      write_reg(ldf_pkg::REG_STAGE_GAIN, {1'($urandom()), g_pick});
      write_reg(ldf_pkg::REG_FEEDBACK_GAIN, {1'($urandom()), k_pick});
      write_reg(ldf_pkg::REG_NORM_GAIN, n_pick);
      cfg_valid <= 1'b0;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(7))
          0:       smp = $urandom_range(1) ? SMP_MAX : SMP_MIN;
          1, 2:    smp = SW'($signed($urandom_range(8191)) - 4096);
          default: smp = SW'($urandom());
        endcase
        send_sample(smp, 1'b0, '0);
      end
    end

    // Drop valid, let the pipeline empty, then watch for stray results.
    in_valid <= 1'b0;
    steady = 1'b0;
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ladder_lowpass_4pole_zdf_unit_test OK");
    end else begin
      $display("ladder_lowpass_4pole_zdf_unit_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_ucode_rom.sv
hw/rtl/ldf_seq.sv
hw/rtl/ldf_dp.sv
hw/rtl/ladder_lowpass_4pole_zdf_unit.sv
hw/rtl/ldf_checker.sv
tb/ladder_lowpass_4pole_zdf_unit_test.sv
